### src/adjacency_matrix_graph_store_core_defines.svh
// assertion macros for the adjacency matrix graph store core
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_CORE_DEFINES_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_CORE_DEFINES_SVH

// same-cycle implication
`define AMG_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("adjacency matrix core: same-cycle check failed");

// next-cycle implication
`define AMG_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("adjacency matrix core: next-cycle check failed");

`endif

### src/amg_pkg.sv
// shared types, codes and constants of the adjacency matrix graph store
package amg_pkg;

  localparam int CMD_W       = 3;
  localparam int VERT_W      = 4;
  localparam int IN_WEIGHT_W = 16;
  localparam int CNT_W       = 5;
  localparam int LIMIT_W     = 5;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // vertices reachable through a vertex field
  localparam int CNT_MAX = 1 << VERT_W;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam logic [LIMIT_W-1:0] DEF_VERTEX_LIMIT = LIMIT_W'(16);

  localparam logic [CMD_W-1:0] CMD_ADD_VERTEX   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_EDGE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_WEIGHTED = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE_EDGE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE_VERT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CHECK_VERT   = 3'd5;

  localparam logic REG_DIRECTED     = 1'b0;
  localparam logic REG_VERTEX_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_CHK,
    ST_MIRROR,
    ST_WIPE_ROW,
    ST_WIPE_COL,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_DONE
  } state_t;

  // which matrix slot a write goes to
  typedef enum logic [2:0] {
    WA_AB,
    WA_BA,
    WA_AI,
    WA_IA,
    WA_CLR
  } wsel_t;

  typedef struct packed {
    logic  latch;
    logic  rd_scan;
    logic  wr_en;
    wsel_t wr_sel;
    logic  wr_zero;
    logic  idx_clr;
    logic  idx_inc;
    logic  clr_inc;
    logic  pres_set;
    logic  pres_clr;
    logic  ok_set;
    logic  out_load;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             a_ok;
    logic             ab_ok;
    logic             pres_a;
    logic             pres_b;
    logic             undir;
    logic             idx_last;
    logic             slot_one;
    logic             slot_zero;
    logic             clr_last;
    logic             out_busy;
  } stat_t;

endpackage

### src/amg_ifs.sv
// command and result channel interfaces
interface amg_cmd_if import amg_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              command;
  logic [VERT_W-1:0]             vertex_a;
  logic [VERT_W-1:0]             vertex_b;
  logic signed [IN_WEIGHT_W-1:0] weight;

  modport source(output valid, command, vertex_a, vertex_b, weight, input ready);
  modport sink(input valid, command, vertex_a, vertex_b, weight, output ready);
endinterface

interface amg_res_if import amg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [CNT_W-1:0] vertex_count;
  logic             empty_res;

  modport source(output valid, ok, vertex_count, empty_res, input ready);
  modport sink(input valid, ok, vertex_count, empty_res, output ready);
endinterface

### src/amg_ram.sv
// generic simple dual-port ram with registered read
module amg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/amg_ctrl.sv
// command sequencer of the graph store
module amg_ctrl import amg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctrl        = '0;
    ctrl.wr_sel = WA_AB;
    cmd_ready   = 1'b0;
    state_next  = state;
    unique case (state)
      ST_CLEAR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wr_sel  = WA_CLR;
        ctrl.wr_zero = 1'b1;
        ctrl.clr_inc = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctrl.latch = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_DONE;
        unique case (stat.cmd)
          CMD_ADD_VERTEX: begin
            if (stat.a_ok && !stat.pres_a) begin
              ctrl.pres_set = 1'b1;
              ctrl.ok_set   = 1'b1;
            end
          end
          CMD_ADD_EDGE: begin
            // slot (a,b) is read here, checked next cycle
            if (stat.ab_ok && stat.pres_a && stat.pres_b) begin
              state_next = ST_EDGE_CHK;
            end
          end
          CMD_ADD_WEIGHTED: begin
            if (stat.ab_ok) begin
              state_next = ST_EDGE_CHK;
            end
          end
          CMD_REMOVE_EDGE: begin
            if (stat.ab_ok) begin
              ctrl.wr_en  = 1'b1;
              ctrl.wr_sel = WA_AB;
              ctrl.ok_set = 1'b1;
              if (stat.undir) begin
                state_next = ST_MIRROR;
              end
            end
          end
          CMD_REMOVE_VERT: begin
            if (stat.a_ok && stat.pres_a) begin
              ctrl.idx_clr = 1'b1;
              state_next   = ST_WIPE_ROW;
            end
          end
          CMD_CHECK_VERT: begin
            if (stat.a_ok && stat.pres_a) begin
              ctrl.idx_clr = 1'b1;
              state_next   = ST_SCAN;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_EDGE_CHK: begin
        state_next = ST_DONE;
        if ((stat.cmd == CMD_ADD_EDGE) ? !stat.slot_one : stat.slot_zero) begin
          ctrl.wr_en  = 1'b1;
          ctrl.wr_sel = WA_AB;
          ctrl.ok_set = 1'b1;
          if (stat.undir) begin
            state_next = ST_MIRROR;
          end
        end
      end
      ST_MIRROR: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_sel = WA_BA;
        state_next  = ST_DONE;
      end
      ST_WIPE_ROW: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wr_sel  = WA_AI;
        ctrl.wr_zero = 1'b1;
        if (stat.undir) begin
          state_next = ST_WIPE_COL;
        end else if (stat.idx_last) begin
          ctrl.pres_clr = 1'b1;
          ctrl.ok_set   = 1'b1;
          state_next    = ST_DONE;
        end else begin
          ctrl.idx_inc = 1'b1;
        end
      end
      ST_WIPE_COL: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wr_sel  = WA_IA;
        ctrl.wr_zero = 1'b1;
        if (stat.idx_last) begin
          ctrl.pres_clr = 1'b1;
          ctrl.ok_set   = 1'b1;
          state_next    = ST_DONE;
        end else begin
          ctrl.idx_inc = 1'b1;
          state_next   = ST_WIPE_ROW;
        end
      end
      ST_SCAN: begin
        // one row word read per cycle, compared in the next cycle
        ctrl.rd_scan = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_SCAN_TAIL;
        end else begin
          ctrl.idx_inc = 1'b1;
        end
      end
      ST_SCAN_TAIL: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          ctrl.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/amg_datapath.sv
// matrix store, vertex marks, counters and result register
module amg_datapath import amg_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctrl_t                         ctrl,
  output stat_t                         stat,
  input  logic                          directed,
  input  logic [LIMIT_W-1:0]            vertex_limit,
  input  logic [CMD_W-1:0]              command,
  input  logic [VERT_W-1:0]             vertex_a,
  input  logic [VERT_W-1:0]             vertex_b,
  input  logic signed [IN_WEIGHT_W-1:0] weight,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic                          ok,
  output logic [CNT_W-1:0]              vertex_count,
  output logic                          empty_res
);

  localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int ADDR_W = 2 * VIDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int LIM_W  = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W  = (LIM_W > LIMIT_W) ? LIM_W : LIMIT_W;

  logic [CMD_W-1:0]              cmd_r;
  logic [VERT_W-1:0]             a_r;
  logic [VERT_W-1:0]             b_r;
  logic signed [IN_WEIGHT_W-1:0] w_r;
  logic [MAX_VERTICES-1:0]       present;
  logic [CNT_W-1:0]              count;
  logic [VIDX_W-1:0]             idx;
  logic [ADDR_W-1:0]             clr_addr;
  logic                          ok_r;
  logic                          rd_pend;

  logic [VIDX_W-1:0]      ra;
  logic [VIDX_W-1:0]      rb;
  logic [CMP_W-1:0]       lim;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic [WEIGHT_BITS-1:0] wdata;
  logic [WEIGHT_BITS-1:0] op_val;
  logic [WEIGHT_BITS-1:0] rdata;

  assign ra = VIDX_W'(a_r);
  assign rb = VIDX_W'(b_r);

  // slots beyond the build size are never in range
  assign lim = (CMP_W'(vertex_limit) > CMP_W'(MAX_VERTICES)) ?
               CMP_W'(MAX_VERTICES) : CMP_W'(vertex_limit);

  always_comb begin
    case (cmd_r)
      CMD_ADD_EDGE:     op_val = WEIGHT_BITS'(1);
      CMD_ADD_WEIGHTED: op_val = WEIGHT_BITS'(w_r);
      default:          op_val = '0;
    endcase
  end

  assign wdata = ctrl.wr_zero ? '0 : op_val;

  always_comb begin
    unique case (ctrl.wr_sel)
      WA_AB:   waddr = {ra, rb};
      WA_BA:   waddr = {rb, ra};
      WA_AI:   waddr = {ra, idx};
      WA_IA:   waddr = {idx, ra};
      WA_CLR:  waddr = clr_addr;
      default: waddr = clr_addr;
    endcase
  end

  assign raddr = ctrl.rd_scan ? {ra, idx} : {ra, rb};

  amg_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (ctrl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    stat           = '0;
    stat.cmd       = cmd_r;
    stat.a_ok      = CMP_W'(a_r) < lim;
    stat.ab_ok     = (CMP_W'(a_r) < lim) && (CMP_W'(b_r) < lim);
    stat.pres_a    = stat.a_ok && present[ra];
    stat.pres_b    = stat.ab_ok && present[rb];
    stat.undir     = !directed;
    stat.idx_last  = (CMP_W'(idx) + CMP_W'(1)) == lim;
    stat.slot_one  = rdata == WEIGHT_BITS'(1);
    stat.slot_zero = rdata == '0;
    stat.clr_last  = &clr_addr;
    stat.out_busy  = res_valid && !res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      count     <= '0;
      clr_addr  <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ctrl.clr_inc) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      rd_pend <= ctrl.rd_scan;
      if (ctrl.pres_set) begin
        present[ra] <= 1'b1;
        count       <= count + CNT_W'(1);
      end else if (ctrl.pres_clr) begin
        present[ra] <= 1'b0;
        if (count != '0) begin
          count <= count - CNT_W'(1);
        end
      end
      if (ctrl.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r <= command;
      a_r   <= vertex_a;
      b_r   <= vertex_b;
      w_r   <= weight;
      ok_r  <= 1'b0;
    end else if (ctrl.ok_set || (rd_pend && stat.slot_one)) begin
      ok_r <= 1'b1;
    end
    if (ctrl.idx_clr) begin
      idx <= '0;
    end else if (ctrl.idx_inc) begin
      idx <= idx + VIDX_W'(1);
    end
    if (ctrl.out_load) begin
      ok           <= ok_r;
      vertex_count <= count;
      empty_res    <= count == '0;
    end
  end

endmodule

### src/adjacency_matrix_graph_store_core.sv
// Adjacency matrix graph store: one command word in, one result word out. After reset the
// matrix ram is swept to zero over all 2**(2*ceil(log2(MAX_VERTICES))) slots (256 at the
// default size) before the first command is taken; APB writes are taken meanwhile. Each
// command then occupies the sequencer from accept to result: add vertex sets a mark; edge
// adds read the slot and write it if the check passes, edge removal writes it at once, and
// both write the mirrored slot when undirected; remove vertex clears its row, alternating
// with its column when undirected, and check vertex scans its row, up to the vertex limit
// capped at MAX_VERTICES. With one ram write port, clears go one slot per cycle. A finished
// result sits in an output register, so the next command is accepted while it waits.
`include "adjacency_matrix_graph_store_core_defines.svh"

module adjacency_matrix_graph_store_core import amg_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  amg_cmd_if.sink           cmd,
  amg_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic               directed;
  logic [LIMIT_W-1:0] vertex_limit;
  ctrl_t              ctrl;
  stat_t              stat;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      directed     <= 1'b0;
      vertex_limit <= DEF_VERTEX_LIMIT;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DIRECTED:     directed     <= pwdata[0];
        REG_VERTEX_LIMIT: vertex_limit <= pwdata[LIMIT_W-1:0];
        default:          directed     <= directed;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DIRECTED:     prdata = APB_DW'(directed);
      REG_VERTEX_LIMIT: prdata = APB_DW'(vertex_limit);
      default:          prdata = '0;
    endcase
  end

  amg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  amg_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .directed     (directed),
    .vertex_limit (vertex_limit),
    .command      (cmd.command),
    .vertex_a     (cmd.vertex_a),
    .vertex_b     (cmd.vertex_b),
    .weight       (cmd.weight),
    .res_ready    (res.ready),
    .res_valid    (res.valid),
    .ok           (res.ok),
    .vertex_count (res.vertex_count),
    .empty_res    (res.empty_res)
  );

  // one command in flight at a time
  `AMG_ASSERT_NEXT(a_one_in_flight, clk, rst, cmd.valid && cmd.ready, !cmd.ready)
  `AMG_ASSERT_SAME(a_empty_matches, clk, rst, res.valid, res.empty_res == (res.vertex_count == '0))
  `AMG_ASSERT_SAME(a_count_bound, clk, rst, res.valid, res.vertex_count <= CNT_W'(CNT_MAX))

endmodule

### test/amg_graph_checker.sv
// result checker for the adjacency matrix graph store: tracks config, predicts each word, compares
`timescale 1ns / 100ps

module amg_graph_checker import amg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  amg_cmd_if                cmd,
  amg_res_if                res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                pending,
  output int                errors
);

  localparam int SLOTS = DEF_MAX_VERTICES;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] vertex_count;
    logic             empty_res;
  } outcome_t;

  logic [DEF_WEIGHT_BITS-1:0] weights [SLOTS][SLOTS];
  logic                       present [SLOTS];
  logic [CNT_W-1:0]           present_total;
  logic                       directed_mode;
  logic [LIMIT_W-1:0]         limit_reg;
  outcome_t                   outcomes_due [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t graph checker: %s", $time, msg);
    errors++;
  endtask

  // updates the shadow graph for one command word and returns the word it should produce
  function automatic outcome_t apply_command(input logic [CMD_W-1:0] op,
                                             input logic [VERT_W-1:0] a,
                                             input logic [VERT_W-1:0] b,
                                             input logic [IN_WEIGHT_W-1:0] w);
    int       span;
    int       i;
    logic     a_in;
    logic     ab_in;
    logic     mirror;
    logic     ok;
    outcome_t o;
    span = (limit_reg > SLOTS) ? SLOTS : int'(limit_reg);
    a_in = int'(a) < span;
    ab_in = a_in && (int'(b) < span);
    mirror = !directed_mode;
    ok = 1'b0;
    case (op)
      CMD_ADD_VERTEX: begin
        if (a_in && !present[a]) begin
          present[a] = 1'b1;
          present_total++;
          ok = 1'b1;
        end
      end
      CMD_ADD_EDGE: begin
        if (ab_in && present[a] && present[b] && weights[a][b] != 1) begin
          weights[a][b] = 1;
          if (mirror) weights[b][a] = 1;
          ok = 1'b1;
        end
      end
      CMD_ADD_WEIGHTED: begin
        // zero weight is accepted but leaves the slot empty
        if (ab_in && weights[a][b] == 0) begin
          weights[a][b] = DEF_WEIGHT_BITS'(w);
          if (mirror) weights[b][a] = DEF_WEIGHT_BITS'(w);
          ok = 1'b1;
        end
      end
      CMD_REMOVE_EDGE: begin
        if (ab_in) begin
          weights[a][b] = '0;
          if (mirror) weights[b][a] = '0;
          ok = 1'b1;
        end
      end
      CMD_REMOVE_VERT: begin
        if (a_in && present[a]) begin
          for (i = 0; i < span; i++) begin
            weights[a][i] = '0;
            if (mirror) weights[i][a] = '0;
          end
          present[a] = 1'b0;
          if (present_total != 0) present_total--;
          ok = 1'b1;
        end
      end
      CMD_CHECK_VERT: begin
        if (a_in && present[a]) begin
          for (i = 0; i < span; i++) begin
            if (weights[a][i] == 1) ok = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    o.ok = ok;
    o.vertex_count = present_total;
    o.empty_res = (present_total == 0);
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      for (int r = 0; r < SLOTS; r++) begin
        present[r] = 1'b0;
        for (int c = 0; c < SLOTS; c++) weights[r][c] = '0;
      end
      present_total = '0;
      directed_mode = 1'b0;
      limit_reg = DEF_VERTEX_LIMIT;
      outcomes_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {REG_DIRECTED, 2'b00}:     directed_mode = pwdata[0];
          {REG_VERTEX_LIMIT, 2'b00}: limit_reg = pwdata[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      // retire before predicting: a word leaving now belongs to an older command
      if (res.valid && res.ready) begin
        got = '{res.ok, res.vertex_count, res.empty_res};
        if (outcomes_due.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing outstanding: ok %0b count %0d",
                                  got.ok, got.vertex_count));
        end else begin
          want = outcomes_due.pop_front();
          if (got.ok !== want.ok)
            flag_mismatch($sformatf("ok got %0b want %0b", got.ok, want.ok));
          if (got.vertex_count !== want.vertex_count)
            flag_mismatch($sformatf("vertex_count got %0d want %0d",
                                    got.vertex_count, want.vertex_count));
          if (got.empty_res !== want.empty_res)
            flag_mismatch($sformatf("empty_res got %0b want %0b",
                                    got.empty_res, want.empty_res));
        end
      end
      if (cmd.valid && cmd.ready)
        outcomes_due.push_back(apply_command(cmd.command, cmd.vertex_a, cmd.vertex_b,
                                             cmd.weight));
    end
    pending = outcomes_due.size();
  end

endmodule

### test/adjacency_matrix_graph_store_core_tb.sv
// top of the graph store bench: clock, reset, command and register stimulus, verdict
`timescale 1ns / 100ps

module adjacency_matrix_graph_store_core_tb;
  import amg_pkg::*;

  localparam logic [CMD_W-1:0] CMD_BAD_LO = CMD_CHECK_VERT + 3'd1;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = {CMD_W{1'b1}};
  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 88;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                pending;
  int                errors;
  int                send_idle;
  int                recv_idle;
  int                cur_span;

  amg_cmd_if cmd_if ();
  amg_res_if res_if ();

  adjacency_matrix_graph_store_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .res    (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  amg_graph_checker u_checker (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .res    (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .pready (pready),
    .paddr  (paddr),
    .pwdata (pwdata),
    .pending(pending),
    .errors (errors)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // result side backpressure
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] op, input logic [VERT_W-1:0] va,
                           input logic [VERT_W-1:0] vb,
                           input logic [IN_WEIGHT_W-1:0] w);
    while ($urandom_range(99) < send_idle) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.command <= op;
    cmd_if.vertex_a <= va;
    cmd_if.vertex_b <= vb;
    cmd_if.weight <= w;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  // hold off until every outstanding word has come back
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // idle before returning, so a following write starts on a later edge
    @(posedge clk);
  endtask

  // mostly in-range picks so the graph actually fills up
  function automatic logic [VERT_W-1:0] pick_vertex();
    if (cur_span != 0 && $urandom_range(99) < 85)
      return VERT_W'($urandom_range(cur_span - 1));
    return VERT_W'($urandom);
  endfunction

  task automatic send_random_word();
    int unsigned                roll;
    logic [CMD_W-1:0]           op;
    logic [IN_WEIGHT_W-1:0]     w;
    roll = $urandom_range(99);
    if (roll < 20) op = CMD_ADD_VERTEX;
    else if (roll < 45) op = CMD_ADD_EDGE;
    else if (roll < 57) op = CMD_ADD_WEIGHTED;
    else if (roll < 67) op = CMD_REMOVE_EDGE;
    else if (roll < 77) op = CMD_REMOVE_VERT;
    else if (roll < 95) op = CMD_CHECK_VERT;
    else op = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    case ($urandom_range(5))
      0: w = '0;
      1: w = IN_WEIGHT_W'(1);
      2: w = '1;
      3: w = {1'b1, {(IN_WEIGHT_W-1){1'b0}}};
      default: w = IN_WEIGHT_W'($urandom);
    endcase
    send_word(op, pick_vertex(), pick_vertex(), w);
  endtask

  initial begin
    logic             dir_sel;
    logic [APB_DW-1:0] lim_sel;
    int               n_words;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.command <= CMD_ADD_VERTEX;
    cmd_if.vertex_a <= '0;
    cmd_if.vertex_b <= '0;
    cmd_if.weight <= '0;
    send_idle = 18;
    recv_idle = 48;
    cur_span = DEF_MAX_VERTICES;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset configuration: undirected, all slots in use
    send_word(CMD_CHECK_VERT,   4'd0,  4'd0,  16'h0000);
    send_word(CMD_REMOVE_VERT,  4'd3,  4'd15, 16'h0000);
    send_word(CMD_ADD_VERTEX,   4'd0,  4'd0,  16'h0000);
    send_word(CMD_ADD_VERTEX,   4'd15, 4'd15, 16'hffff);
    send_word(CMD_ADD_VERTEX,   4'd0,  4'd0,  16'h0000);
    send_word(CMD_ADD_EDGE,     4'd0,  4'd15, 16'h0000);
    send_word(CMD_ADD_EDGE,     4'd0,  4'd15, 16'h0000);
    send_word(CMD_ADD_EDGE,     4'd0,  4'd5,  16'h0000);
    // weighted adds skip the presence check
    send_word(CMD_ADD_WEIGHTED, 4'd3,  4'd4,  16'h8000);
    send_word(CMD_ADD_WEIGHTED, 4'd3,  4'd4,  16'h7fff);
    send_word(CMD_ADD_WEIGHTED, 4'd5,  4'd6,  16'h0000);
    send_word(CMD_ADD_WEIGHTED, 4'd5,  4'd6,  16'h7fff);
    send_word(CMD_ADD_VERTEX,   4'd3,  4'd0,  16'h0000);
    send_word(CMD_ADD_VERTEX,   4'd4,  4'd0,  16'h0000);
    // mirrored weight gets overwritten with a plain edge
    send_word(CMD_ADD_EDGE,     4'd4,  4'd3,  16'h0000);
    send_word(CMD_CHECK_VERT,   4'd15, 4'd0,  16'h0000);
    send_word(CMD_CHECK_VERT,   4'd3,  4'd0,  16'h0000);
    send_word(CMD_REMOVE_EDGE,  4'd0,  4'd15, 16'h0000);
    send_word(CMD_REMOVE_EDGE,  4'd9,  4'd10, 16'h0000);
    send_word(CMD_CHECK_VERT,   4'd0,  4'd0,  16'h0000);
    send_word(CMD_REMOVE_VERT,  4'd3,  4'd0,  16'h0000);
    send_word(CMD_REMOVE_VERT,  4'd3,  4'd0,  16'h0000);
    send_word(CMD_CHECK_VERT,   4'd4,  4'd0,  16'h0000);
    send_word(CMD_BAD_LO,       4'd15, 4'd15, 16'hffff);
    send_word(CMD_BAD_HI,       4'd0,  4'd0,  16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_idle = 18;
        recv_idle = 48;
      end else if (p < 6) begin
        send_idle = 48;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      dir_sel = p[0];
      case (p)
        1:       lim_sel = 32'd16;
        2:       lim_sel = 32'd1;
        3:       lim_sel = 32'd5;
        4:       lim_sel = 32'd31;
        5:       lim_sel = 32'd0;
        6:       lim_sel = 32'd8;
        8:       lim_sel = 32'd12;
        default: lim_sel = 32'd16;
      endcase
      // phase 0 keeps the reset values of both registers
      if (p != 0) begin
        wait_drained();
        reg_write({REG_DIRECTED, 2'b00}, APB_DW'(dir_sel));
        reg_write({REG_VERTEX_LIMIT, 2'b00}, lim_sel);
        cur_span = (lim_sel > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(lim_sel);
      end
      n_words = (cur_span == 0) ? 30 : WORDS_PER_PHASE;
      for (int k = 0; k < n_words; k++) begin
        if (p == 0 && k == n_words / 2) wait_drained();
        send_random_word();
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
